>>> hdl/odpc_pkg.sv
`timescale 1ns / 1ps

package odpc_pkg;

	// Fixed field widths
	localparam int CNT_W     = 14;
	localparam int FRAC_BITS = 8;
	localparam int RATIO_W   = 22;
	localparam int DIV_W     = CNT_W + FRAC_BITS;
	localparam int STEP_W    = $clog2(DIV_W);
	localparam int BYTE_W    = 8;

	localparam int COUNT_LIMIT_DEF = 9999;

	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;

	// Command bytes
	localparam logic [BYTE_W-1:0] CMD_START   = 8'd49;
	localparam logic [BYTE_W-1:0] CMD_CONFIRM = 8'd50;
	localparam logic [BYTE_W-1:0] CMD_PULSE   = 8'd251;
	localparam logic [BYTE_W-1:0] CMD_QUAD    = 8'd252;
	localparam logic [BYTE_W-1:0] CMD_REMOTE  = 8'd253;

	typedef enum logic [1:0] {
		OP_EDGE_A = 2'd0,
		OP_EDGE_B = 2'd1,
		OP_BYTE   = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_REF     = 2'd1,
		PH_CONFIRM = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		DK_SHOW,
		DK_REPORT,
		DK_CONFIRM
	} div_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hdl/odpc_if.sv
`timescale 1ns / 1ps

interface odpc_item_if;
	logic                        valid;
	logic                        ready;
	odpc_pkg::op_t               opcode;
	logic                        pin_a_level;
	logic                        pin_b_level;
	logic                        direction_level;
	logic [odpc_pkg::BYTE_W-1:0] rx_byte;
	logic                        button_pressed;

	modport source (output valid, opcode, pin_a_level, pin_b_level, direction_level,
		rx_byte, button_pressed, input ready);
	modport sink (input valid, opcode, pin_a_level, pin_b_level, direction_level,
		rx_byte, button_pressed, output ready);
endinterface

interface odpc_result_if;
	logic                         valid;
	logic                         ready;
	logic [odpc_pkg::CNT_W-1:0]   pulse_count;
	logic [odpc_pkg::CNT_W-1:0]   shown_distance;
	logic                         report_valid;
	logic [odpc_pkg::CNT_W-1:0]   report_distance;
	logic                         calibrating;
	logic [1:0]                   cal_phase_out;
	logic                         quadrature_mode;
	logic [odpc_pkg::RATIO_W-1:0] ratio_out;

	modport source (output valid, pulse_count, shown_distance, report_valid,
		report_distance, calibrating, cal_phase_out, quadrature_mode, ratio_out,
		input ready);
	modport sink (input valid, pulse_count, shown_distance, report_valid,
		report_distance, calibrating, cal_phase_out, quadrature_mode, ratio_out,
		output ready);
endinterface

>>> hdl/odpc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module odpc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  odpc_pkg::div_req_t req,
	output odpc_pkg::div_rsp_t rsp
);
	import odpc_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    trial_sub;
	logic              fits;

	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("divider not busy after start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && step_q == LAST_STEP) |=> done_q)
		else $error("divider missed done after last step");
endmodule

>>> hdl/odometer_pulse_counter_calibrated.sv
// Flow: an accepted input beat starts the divider, which makes one quotient bit per step;
// when it is done the sequencer waits for the output register and loads the result beat.
// Beats: one at a time; none is taken until the last result is loaded, but a new beat is
// taken while the previous result still waits in the output register. Reset: arst_n
// clears control and odometer state but the reference byte at once (count 0, quadrature
// mode, ratio 1.0); no clearing pass, the block is ready on the first cycle after reset.
`timescale 1ns / 1ps

module odometer_pulse_counter_calibrated #(
	parameter int COUNT_LIMIT = odpc_pkg::COUNT_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	odpc_item_if.sink     item_in,
	odpc_result_if.source result_out
);
	import odpc_pkg::*;

	localparam logic [CNT_W-1:0]   LIMIT_C   = CNT_W'(COUNT_LIMIT);
	localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(COUNT_LIMIT) << FRAC_BITS;

	// Odometer state
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         enc_last_q;
	logic               enc_half_q;
	logic               mode_quad_q;
	logic               cal_disp_q;
	phase_t             phase_q;
	logic [BYTE_W-1:0]  ref_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               pend_q;
	logic               latch_q;
	div_kind_t          kind_q;

	// Next values on an accepted beat
	logic [CNT_W-1:0]   count_d;
	logic [1:0]         enc_last_d;
	logic               enc_half_d;
	logic               mode_quad_d;
	logic               cal_disp_d;
	phase_t             phase_d;
	logic [BYTE_W-1:0]  ref_d;
	logic [RATIO_W-1:0] ratio_d;
	logic               pend_d;
	logic               latch_d;
	div_kind_t          kind_d;

	logic [CNT_W-1:0]   count_up;
	logic [CNT_W-1:0]   count_dn;
	logic [1:0]         enc_pos;
	logic [1:0]         enc_diff;
	logic [CNT_W-1:0]   div_count;

	// Sequencer
	state_t   state_q;
	state_t   state_d;
	logic     accept;
	logic     load_out;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Output register
	logic               out_valid_q;
	logic [CNT_W-1:0]   out_count_q;
	logic [CNT_W-1:0]   out_shown_q;
	logic               out_rep_valid_q;
	logic [CNT_W-1:0]   out_rep_dist_q;
	logic               out_cal_q;
	logic [1:0]         out_phase_q;
	logic               out_mode_q;
	logic [RATIO_W-1:0] out_ratio_q;
	logic [CNT_W-1:0]   quo_cnt;
	logic [RATIO_W-1:0] ratio_confirm;

	assign count_up = (count_q < LIMIT_C) ? count_q + CNT_W'(1) : LIMIT_C;
	assign count_dn = (count_q != '0) ? count_q - CNT_W'(1) : '0;

	// Gray position: bit 1 is pin B low, bit 0 is pin A xor pin B
	assign enc_pos  = {~item_in.pin_b_level, item_in.pin_a_level ^ item_in.pin_b_level};
	assign enc_diff = enc_last_q - enc_pos;

	// Work out the state after the beat and which division it needs
	always_comb begin
		count_d     = count_q;
		enc_last_d  = enc_last_q;
		enc_half_d  = enc_half_q;
		mode_quad_d = mode_quad_q;
		cal_disp_d  = cal_disp_q;
		phase_d     = phase_q;
		ref_d       = ref_q;
		ratio_d     = ratio_q;
		pend_d      = pend_q;
		latch_d     = latch_q;
		kind_d      = DK_SHOW;

		case (item_in.opcode) inside
			OP_EDGE_A, OP_EDGE_B: begin
				if (item_in.opcode == OP_EDGE_A || mode_quad_q) begin
					cal_disp_d = 1'b0;
				end
				if (mode_quad_q) begin
					// An odd difference is one Gray step; two steps move the count once
					if (enc_diff[0]) begin
						enc_last_d = enc_pos;
						enc_half_d = ~enc_half_q;
						if (enc_diff[1] && enc_half_q) begin
							count_d = count_up;
						end else if (!enc_diff[1] && !enc_half_q) begin
							count_d = count_dn;
						end
					end
				end else if (item_in.opcode == OP_EDGE_A) begin
					count_d = item_in.direction_level ? count_up : count_dn;
				end
			end
			OP_BYTE: begin
				if (phase_q == PH_REF) begin
					// Any byte in this phase is the reference distance
					ref_d   = item_in.rx_byte;
					phase_d = PH_CONFIRM;
				end else begin
					case (item_in.rx_byte)
						CMD_START: begin
							cal_disp_d = 1'b1;
							count_d    = '0;
							ratio_d    = RATIO_ONE;
							phase_d    = PH_REF;
						end
						CMD_CONFIRM: begin
							if (phase_q == PH_CONFIRM) begin
								kind_d     = DK_CONFIRM;
								cal_disp_d = 1'b0;
								count_d    = '0;
								phase_d    = PH_IDLE;
							end
						end
						CMD_PULSE:  mode_quad_d = 1'b0;
						CMD_QUAD:   mode_quad_d = 1'b1;
						CMD_REMOTE: pend_d = 1'b1;
						default: ;
					endcase
				end
			end
			default: begin
				if ((item_in.button_pressed && phase_q == PH_IDLE && !latch_q) || pend_q) begin
					kind_d  = DK_REPORT;
					count_d = '0;
					pend_d  = 1'b0;
					latch_d = 1'b1;
				end else begin
					latch_d = 1'b0;
				end
			end
		endcase
	end

	// Report and confirm divide the count before clearing; otherwise the new count
	assign div_count        = (kind_d == DK_SHOW) ? count_d : count_q;
	assign div_req.start    = accept;
	assign div_req.dividend = {div_count, {FRAC_BITS{1'b0}}};
	assign div_req.divisor  = (kind_d == DK_CONFIRM) ? DIV_W'(ref_q) : DIV_W'(ratio_d);

	odpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Hold state; advance it on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			enc_last_q  <= '0;
			enc_half_q  <= 1'b0;
			mode_quad_q <= 1'b1;
			cal_disp_q  <= 1'b0;
			phase_q     <= PH_IDLE;
			pend_q      <= 1'b0;
			latch_q     <= 1'b0;
			kind_q      <= DK_SHOW;
		end else if (accept) begin
			count_q     <= count_d;
			enc_last_q  <= enc_last_d;
			enc_half_q  <= enc_half_d;
			mode_quad_q <= mode_quad_d;
			cal_disp_q  <= cal_disp_d;
			phase_q     <= phase_d;
			pend_q      <= pend_d;
			latch_q     <= latch_d;
			kind_q      <= kind_d;
		end
	end

	// Reference byte needs no reset: confirm only reads it after it was written
	always_ff @(posedge clk) begin
		if (accept) begin
			ref_q <= ref_d;
		end
	end

	// Confirm: zero reference gives the maximum, else the quotient with a floor of 1.0
	assign ratio_confirm = (ref_q == '0) ? RATIO_MAX :
		((div_rsp.quotient < RATIO_ONE) ? RATIO_ONE : div_rsp.quotient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_ONE;
		end else if (accept) begin
			ratio_q <= ratio_d;
		end else if (state_q == ST_DIV && div_rsp.done && kind_q == DK_CONFIRM) begin
			ratio_q <= ratio_confirm;
		end
	end

	// Sequencer: idle, divide, wait for the output register
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_DIV;
			ST_DIV:  if (div_rsp.done) state_d = ST_WAIT;
			ST_WAIT: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_in.ready = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: item_in.ready = 1'b1;
			ST_DIV:  ;
			ST_WAIT: load_out = !out_valid_q || result_out.ready;
			default: ;
		endcase
	end

	assign accept = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register: hold the result beat until the sink takes it
	assign quo_cnt = div_rsp.quotient[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_count_q     <= count_q;
			out_shown_q     <= (kind_q == DK_SHOW) ? quo_cnt : '0;
			out_rep_valid_q <= (kind_q == DK_REPORT);
			out_rep_dist_q  <= (kind_q == DK_REPORT) ? quo_cnt : '0;
			out_cal_q       <= cal_disp_q;
			out_phase_q     <= phase_q;
			out_mode_q      <= mode_quad_q;
			out_ratio_q     <= ratio_q;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.pulse_count     = out_count_q;
	assign result_out.shown_distance  = out_shown_q;
	assign result_out.report_valid    = out_rep_valid_q;
	assign result_out.report_distance = out_rep_dist_q;
	assign result_out.calibrating     = out_cal_q;
	assign result_out.cal_phase_out   = out_phase_q;
	assign result_out.quadrature_mode = out_mode_q;
	assign result_out.ratio_out       = out_ratio_q;

	a_div_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_rsp.done) |=> state_q == ST_WAIT)
		else $error("sequencer missed divider done");
	a_ratio_floor: assert property (@(posedge clk) disable iff (!arst_n)
		ratio_q >= RATIO_ONE)
		else $error("ratio below 1.0");
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LIMIT_C)
		else $error("count above limit");
	a_load_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_out.ready) |-> !load_out)
		else $error("output overwritten while stalled");
endmodule
